@@ hdl/mpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-pattern byte matcher package
// Shared constants, register codes and the structs that pass between the
// matcher cells, the register block and the top level.
// ----------------------------------------------------------------------------
package mpbm_pkg;

    localparam int MAX_RULES       = 4;
    localparam int MAX_PATTERN_LEN = 64;
    localparam int LEN_REGS        = 4;

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 3;
    localparam int LEN_W      = 7;
    localparam int SLOT_W     = 2;
    localparam int POS_W      = 6;
    localparam int RULE_IDX_W = 2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RULE_COUNT   = 3'd0,
        REG_LENGTH_RULE0 = 3'd1,
        REG_LENGTH_RULE1 = 3'd2,
        REG_LENGTH_RULE2 = 3'd3,
        REG_LENGTH_RULE3 = 3'd4
    } reg_idx_t;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_SCAN = 1'b1
    } mode_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                rule_count;
        logic [LEN_REGS-1:0][LEN_W-1:0]    rule_len;
    } cfg_t;

    // Broadcast to every cell for a scanned byte or a window replay cycle.
    typedef struct packed {
        logic              scan;
        logic              last;
        logic              flush;
        logic              replay;
        logic              step;
        logic [BYTE_W-1:0] data;
    } cell_ctl_t;

    // Pattern byte write aimed at one cell.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] data;
    } cell_load_t;

endpackage

@@ hdl/mpbm_stream_if.sv @@
// ----------------------------------------------------------------------------
// Multi-pattern byte matcher channels
// Valid/ready channels for input items and for match reports.
// ----------------------------------------------------------------------------
interface mpbm_in_if;
    import mpbm_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [SLOT_W-1:0]   rule_slot;
    logic [POS_W-1:0]    byte_position;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;

    modport source (
        output valid, mode, rule_slot, byte_position, data_byte, last_byte,
        input  ready
    );

    modport sink (
        input  valid, mode, rule_slot, byte_position, data_byte, last_byte,
        output ready
    );
endinterface

interface mpbm_out_if;
    import mpbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  matched;
    logic [RULE_IDX_W-1:0] rule_index;

    modport source (
        output valid, matched, rule_index,
        input  ready
    );

    modport sink (
        input  valid, matched, rule_index,
        output ready
    );
endinterface

@@ hdl/mpbm_cfg.sv @@
// ----------------------------------------------------------------------------
// Multi-pattern byte matcher register block
// APB-style register file holding the rule count and the pattern lengths.
// ----------------------------------------------------------------------------
module mpbm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpbm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mpbm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpbm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output mpbm_pkg::cfg_t                  cfg
);
    import mpbm_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_RULE_COUNT:   cfg_next.rule_count  = pwdata[COUNT_W-1:0];
                REG_LENGTH_RULE0: cfg_next.rule_len[0] = pwdata[LEN_W-1:0];
                REG_LENGTH_RULE1: cfg_next.rule_len[1] = pwdata[LEN_W-1:0];
                REG_LENGTH_RULE2: cfg_next.rule_len[2] = pwdata[LEN_W-1:0];
                REG_LENGTH_RULE3: cfg_next.rule_len[3] = pwdata[LEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RULE_COUNT:   prdata = APB_DATA_W'(cfg_reg.rule_count);
            REG_LENGTH_RULE0: prdata = APB_DATA_W'(cfg_reg.rule_len[0]);
            REG_LENGTH_RULE1: prdata = APB_DATA_W'(cfg_reg.rule_len[1]);
            REG_LENGTH_RULE2: prdata = APB_DATA_W'(cfg_reg.rule_len[2]);
            REG_LENGTH_RULE3: prdata = APB_DATA_W'(cfg_reg.rule_len[3]);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/mpbm_cell.sv @@
// ----------------------------------------------------------------------------
// Multi-pattern byte matcher cell
// Holds one pattern position of every rule, one byte of the window of recent
// buffer bytes and the partial-match bits that say the pattern prefix up to
// and including this position ends at the most recent byte.
// ----------------------------------------------------------------------------
module mpbm_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpbm_pkg::cell_ctl_t            ctl,
    input  mpbm_pkg::cell_load_t           load,
    input  logic [mpbm_pkg::MAX_RULES-1:0] match_in,
    output logic [mpbm_pkg::MAX_RULES-1:0] match_out,
    output logic [mpbm_pkg::MAX_RULES-1:0] match_now,
    input  logic [mpbm_pkg::BYTE_W-1:0]    win_in,
    output logic [mpbm_pkg::BYTE_W-1:0]    win_out
);
    import mpbm_pkg::*;

    logic [MAX_RULES-1:0][BYTE_W-1:0] pat_reg;
    logic [MAX_RULES-1:0][BYTE_W-1:0] pat_next;
    logic [MAX_RULES-1:0]             match_reg;
    logic [MAX_RULES-1:0]             match_next;
    logic [BYTE_W-1:0]                win_reg;
    logic [BYTE_W-1:0]                win_next;

    always_comb
    begin
        pat_next = pat_reg;
        if (load.en)
        begin
            pat_next[load.slot] = load.data;
        end
    end

    // The prefix extends by one byte when the neighbor's prefix held before
    // this byte and this byte equals the stored pattern byte.
    always_comb
    begin
        for (int r = 0; r < MAX_RULES; r++)
        begin
            match_now[r] = match_in[r] && (ctl.data == pat_reg[r]);
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctl.flush)
        begin
            match_next = '0;
        end
        else if (ctl.scan)
        begin
            match_next = ctl.last ? '0 : match_now;
        end
        else if (ctl.step)
        begin
            match_next = match_now;
        end
    end

    always_comb
    begin
        win_next = win_reg;
        if (ctl.scan || ctl.replay)
        begin
            win_next = win_in;
        end
    end

    assign match_out = match_reg;
    assign win_out   = win_reg;

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
            win_reg   <= '0;
        end
        else
        begin
            match_reg <= match_next;
            win_reg   <= win_next;
        end
    end

endmodule

@@ hdl/multi_pattern_byte_matcher.sv @@
// ----------------------------------------------------------------------------
// Multi-pattern byte matcher
// Streams buffer bytes through a row of match cells and reports, at the last
// byte of each buffer, the lowest-numbered rule whose pattern occurred.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle in both load and scan mode when not
// held off, with no clearing pass after reset. Each of the 64 cells holds one
// pattern position of all four rules, one byte of the window of recent buffer
// bytes and a partial-match bit per rule, which it hands to the next cell on
// every scanned byte; the byte compare, the pick of the cell at each rule's
// length and the lowest-rule priority settle in the same cycle. A pattern byte
// loaded after at least one byte of the current buffer makes the partial-match
// bits stale, so the block then rotates the window once around the row,
// holding off input, and rebuilds them from the bytes of the buffer against
// the new pattern. A report appears in the output register in the cycle after
// the transfer of the last byte of a buffer, and input is held off for as long
// as a report waits and the receiver is not ready. Pattern bytes that were
// never loaded hold unknown data, so load every byte of a rule before scanning.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher (
    input  logic                            clk,
    input  logic                            rst_n,
    mpbm_in_if.sink                         item,
    mpbm_out_if.source                      report,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpbm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mpbm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpbm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mpbm_pkg::*;

    cfg_t                                   cfg;
    logic                                   accept;
    logic                                   is_scan;
    logic                                   is_load;
    logic                                   report_fire;
    cell_ctl_t                              ctl;
    cell_load_t [MAX_PATTERN_LEN-1:0]       load_bus;
    logic [MAX_PATTERN_LEN:0][MAX_RULES-1:0] chain;
    logic [MAX_PATTERN_LEN-1:0][MAX_RULES-1:0] now_vec;
    logic [MAX_PATTERN_LEN:0][BYTE_W-1:0]   win_chain;

    logic [COUNT_W-1:0]                     n_active;
    logic [MAX_RULES-1:0]                   active;
    logic [MAX_RULES-1:0][LEN_W-1:0]        len_sat;
    logic [MAX_RULES-1:0]                   hit;
    logic [MAX_RULES-1:0]                   hits_total;
    logic [RULE_IDX_W-1:0]                  first_idx;

    logic [MAX_RULES-1:0]                   flags_reg;
    logic [MAX_RULES-1:0]                   flags_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic                                   matched_reg;
    logic                                   matched_next;
    logic [RULE_IDX_W-1:0]                  rule_index_reg;
    logic [RULE_IDX_W-1:0]                  rule_index_next;

    logic [LEN_W-1:0]                       bytes_seen_reg;
    logic [LEN_W-1:0]                       bytes_seen_next;
    logic [LEN_W-1:0]                       rot_cnt_reg;
    logic [LEN_W-1:0]                       rot_cnt_next;
    logic                                   replaying;
    logic                                   start_replay;

    mpbm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign replaying    = (rot_cnt_reg != '0);
    assign item.ready   = !replaying && (!out_valid_reg || report.ready);
    assign accept       = item.valid && item.ready;
    assign is_scan      = accept && (mode_t'(item.mode) == MODE_SCAN);
    assign is_load      = accept && (mode_t'(item.mode) == MODE_LOAD);
    assign report_fire  = is_scan && item.last_byte;
    assign start_replay = is_load && (bytes_seen_reg != '0);

    // During a replay the oldest window byte leaves the far end of the row,
    // feeds the compares and wraps around to the first cell.
    assign ctl.scan   = is_scan;
    assign ctl.last   = item.last_byte;
    assign ctl.flush  = start_replay;
    assign ctl.replay = replaying;
    assign ctl.step   = replaying && (rot_cnt_reg <= bytes_seen_reg);
    assign ctl.data   = replaying ? win_chain[MAX_PATTERN_LEN] : item.data_byte;

    assign win_chain[0] = ctl.data;

    // The empty prefix always matches.
    assign chain[0] = '1;

    for (genvar k = 0; k < MAX_PATTERN_LEN; k++)
    begin : g_cell
        assign load_bus[k].en   = is_load && (item.byte_position == POS_W'(k));
        assign load_bus[k].slot = item.rule_slot;
        assign load_bus[k].data = item.data_byte;

        mpbm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .load      (load_bus[k]),
            .match_in  (chain[k]),
            .match_out (chain[k+1]),
            .match_now (now_vec[k]),
            .win_in    (win_chain[k]),
            .win_out   (win_chain[k+1])
        );
    end

    assign n_active = (cfg.rule_count > COUNT_W'(MAX_RULES)) ?
                      COUNT_W'(MAX_RULES) : cfg.rule_count;

    // A rule hits when the prefix of its full length ends at this byte.
    always_comb
    begin
        for (int r = 0; r < MAX_RULES; r++)
        begin
            active[r]  = COUNT_W'(r) < n_active;
            len_sat[r] = (cfg.rule_len[r] > LEN_W'(MAX_PATTERN_LEN)) ?
                         LEN_W'(MAX_PATTERN_LEN) : cfg.rule_len[r];
            hit[r]     = (len_sat[r] == '0);
            for (int k = 0; k < MAX_PATTERN_LEN; k++)
            begin
                if (len_sat[r] == LEN_W'(k + 1))
                begin
                    hit[r] = now_vec[k][r];
                end
            end
        end
    end

    assign hits_total = (flags_reg | (hit & active)) & active;

    always_comb
    begin
        first_idx = '0;
        for (int r = MAX_RULES - 1; r >= 0; r--)
        begin
            if (hits_total[r])
            begin
                first_idx = RULE_IDX_W'(r);
            end
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (is_scan)
        begin
            flags_next = item.last_byte ? '0 : (flags_reg | (hit & active));
        end
    end

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        if (is_scan)
        begin
            if (item.last_byte)
            begin
                bytes_seen_next = '0;
            end
            else if (bytes_seen_reg < LEN_W'(MAX_PATTERN_LEN))
            begin
                bytes_seen_next = bytes_seen_reg + LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        rot_cnt_next = rot_cnt_reg;
        if (start_replay)
        begin
            rot_cnt_next = LEN_W'(MAX_PATTERN_LEN);
        end
        else if (replaying)
        begin
            rot_cnt_next = rot_cnt_reg - LEN_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !report.ready;
        matched_next    = matched_reg;
        rule_index_next = rule_index_reg;
        if (report_fire)
        begin
            out_valid_next  = 1'b1;
            matched_next    = |hits_total;
            rule_index_next = first_idx;
        end
    end

    assign report.valid      = out_valid_reg;
    assign report.matched    = matched_reg;
    assign report.rule_index = rule_index_reg;

    always_ff @(posedge clk)
    begin
        matched_reg    <= matched_next;
        rule_index_reg <= rule_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg      <= '0;
            out_valid_reg  <= 1'b0;
            bytes_seen_reg <= '0;
            rot_cnt_reg    <= '0;
        end
        else
        begin
            flags_reg      <= flags_next;
            out_valid_reg  <= out_valid_next;
            bytes_seen_reg <= bytes_seen_next;
            rot_cnt_reg    <= rot_cnt_next;
        end
    end

    a_end_of_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        report_fire |=> (flags_reg == '0) && out_valid_reg && (chain[1] == '0))
        else $error("state not cleared after the last byte of a buffer");

    a_no_match_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !matched_reg) |-> (rule_index_reg == '0))
        else $error("rule index set on a report without a match");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!is_scan && !is_load && !replaying) |=>
            $stable(chain[MAX_PATTERN_LEN:1]) && $stable(flags_reg))
        else $error("match state changed without a scanned byte");

endmodule
